/* design/cia_pkg.sv */
// Package of shared types, codes and latencies for the checked integer ALU.
`default_nettype none
package cia_pkg;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_DIV  = 5'd3;
	localparam logic [4:0] OP_REM  = 5'd4;
	localparam logic [4:0] OP_AND  = 5'd5;
	localparam logic [4:0] OP_OR   = 5'd6;
	localparam logic [4:0] OP_XOR  = 5'd7;
	localparam logic [4:0] OP_NEG  = 5'd8;
	localparam logic [4:0] OP_NOT  = 5'd9;
	localparam logic [4:0] OP_SHL  = 5'd10;
	localparam logic [4:0] OP_SHR  = 5'd11;
	localparam logic [4:0] OP_EQ   = 5'd12;
	localparam logic [4:0] OP_NE   = 5'd13;
	localparam logic [4:0] OP_GT   = 5'd14;
	localparam logic [4:0] OP_GE   = 5'd15;
	localparam logic [4:0] OP_LT   = 5'd16;
	localparam logic [4:0] OP_LE   = 5'd17;
	localparam logic [4:0] OP_CADD = 5'd18;
	localparam logic [4:0] OP_CSUB = 5'd19;
	localparam logic [4:0] OP_CMUL = 5'd20;

	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_DIVZERO  = 2'd1;
	localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

	localparam int DIV_LAT = 64;
	localparam int MUL_LAT = 3;
	localparam int MUL_DLY = DIV_LAT - MUL_LAT;

	typedef struct packed {
		logic [4:0]  operation;
		logic        wide;
		logic        is_unsigned;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic [1:0]  fault_code;
	} rsp_t;

	typedef struct packed {
		logic [4:0]  op;
		logic        wide;
		logic        neg_q;
		logic        neg_r;
		logic [63:0] simple;
		logic [1:0]  fault;
	} side_t;

	typedef struct packed {
		logic [63:0] lo;
		logic        ovf;
	} mul_out_t;

endpackage
`default_nettype wire

/* design/cia_mul.sv */
// Three-stage multiplier of magnitudes with wrap result and overflow flag.
`default_nettype none
module cia_mul (
	input  wire logic              clk,
	input  wire logic [63:0]       a,
	input  wire logic [63:0]       b,
	input  wire logic              neg,
	input  wire logic              wide,
	input  wire logic              uns,
	output cia_pkg::mul_out_t      prod
);

	logic [63:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic         neg_s1, wide_s1, uns_s1;
	logic [127:0] p_s2;
	logic         neg_s2, wide_s2, uns_s2;
	logic [63:0]  lo;
	logic         ge, eq, ovf;

	always_ff @(posedge clk) begin
		p00_s1  <= 64'(a[31:0]) * 64'(b[31:0]);
		p01_s1  <= 64'(a[31:0]) * 64'(b[63:32]);
		p10_s1  <= 64'(a[63:32]) * 64'(b[31:0]);
		p11_s1  <= 64'(a[63:32]) * 64'(b[63:32]);
		neg_s1  <= neg;
		wide_s1 <= wide;
		uns_s1  <= uns;
		p_s2    <= {p11_s1, p00_s1} + {32'b0, p01_s1, 32'b0} + {32'b0, p10_s1, 32'b0};
		neg_s2  <= neg_s1;
		wide_s2 <= wide_s1;
		uns_s2  <= uns_s1;
	end

	always_comb begin
		lo = neg_s2 ? (64'd0 - p_s2[63:0]) : p_s2[63:0];
		if (uns_s2) begin
			ge = wide_s2 ? (|p_s2[127:64]) : (|p_s2[63:32]);
			eq = 1'b0;
		end else begin
			ge = wide_s2 ? (|p_s2[127:63]) : (|p_s2[63:31]);
			eq = wide_s2 ? (p_s2 == (128'd1 << 63)) : (p_s2 == (128'd1 << 31));
		end
		ovf = ge && !(neg_s2 && eq);
	end

	always_ff @(posedge clk) begin
		prod.lo  <= lo;
		prod.ovf <= ovf;
	end

endmodule
`default_nettype wire

/* design/cia_div.sv */
// Unsigned restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module cia_div (
	input  wire logic        clk,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic      [63:0] quotient,
	output logic      [63:0] remainder
);

	logic [63:0] rem_s [0:cia_pkg::DIV_LAT-1];
	logic [63:0] quo_s [0:cia_pkg::DIV_LAT-1];
	logic [63:0] dvs_s [0:cia_pkg::DIV_LAT-1];
	logic [63:0] rem_n [0:cia_pkg::DIV_LAT-1];
	logic [63:0] quo_n [0:cia_pkg::DIV_LAT-1];
	logic [63:0] dvs_n [0:cia_pkg::DIV_LAT-1];

	always_comb begin
		logic [63:0] r, q, d;
		logic [64:0] trial, diff;
		for (int k = 0; k < cia_pkg::DIV_LAT; k++) begin
			if (k == 0) begin
				r = 64'd0;
				q = dividend;
				d = divisor;
			end else begin
				r = rem_s[k-1];
				q = quo_s[k-1];
				d = dvs_s[k-1];
			end
			trial = {r, q[63]};
			diff = trial - {1'b0, d};
			rem_n[k] = diff[64] ? trial[63:0] : diff[63:0];
			quo_n[k] = {q[62:0], !diff[64]};
			dvs_n[k] = d;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < cia_pkg::DIV_LAT; k++) begin
			rem_s[k] <= rem_n[k];
			quo_s[k] <= quo_n[k];
			dvs_s[k] <= dvs_n[k];
		end
	end

	assign quotient  = quo_s[cia_pkg::DIV_LAT-1];
	assign remainder = rem_s[cia_pkg::DIV_LAT-1];

endmodule
`default_nettype wire

/* design/checked_integer_alu.sv */
// Top level of the checked integer ALU: decode stage, multiplier, divider and result stage.
//
// A command beat is taken at each rising edge where start is high and busy is low.
// busy never rises: the block is a fixed-latency pipeline and takes a new command in
// every cycle, so the sustained rate is one command per clock.
// Every command gives one result beat: done is high for exactly one cycle, and in that
// cycle result holds the result value and the fault code of that command.
// The latency is set by the divider, which resolves one quotient bit per stage over
// 64 stages; every other operation is delayed to the same depth so results leave in
// command order. The multiplier takes three stages from the decode stage.
// A zero divisor gives a divide-by-zero fault; signed MIN by minus one in DIV or REM and a
// checked operation that does not fit give an overflow fault; a faulted result is zero.
// Narrow results are zero-extended to 64 bits.
// Reset clears the valid bits of the pipeline, so no result beat appears until a
// command has been taken. The receiver cannot stall and must take each beat as it comes.
`default_nettype none
module checked_integer_alu (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire cia_pkg::cmd_t command,
	output logic               done,
	output cia_pkg::rsp_t      result
);

	logic [63:0] mask, a, b, ma, mb, sbit, ca, cb, ax, sum, dif, simple;
	logic        na, nb, uns;
	logic [5:0]  sh;
	logic [1:0]  fault;

	cia_pkg::side_t    side_s1;
	logic              valid_s1;
	logic [63:0]       mula_s1, mulb_s1, dvd_s1, dvs_s1;
	logic              mneg_s1, wide_s1, uns_s1;
	cia_pkg::side_t    side_d [0:cia_pkg::DIV_LAT-1];
	logic              valid_d [0:cia_pkg::DIV_LAT-1];
	cia_pkg::mul_out_t mul_out;
	cia_pkg::mul_out_t mul_d [0:cia_pkg::MUL_DLY-1];
	logic [63:0]       quo, rem;
	cia_pkg::side_t    fin;
	logic [63:0]       fmask, res;
	logic [1:0]        flt;
	logic              done_q;
	cia_pkg::rsp_t     result_q;

	assign busy = 1'b0;

	always_comb begin
		uns  = command.is_unsigned;
		mask = command.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
		sbit = command.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		a    = command.operand_a & mask;
		b    = command.operand_b & mask;
		na   = command.wide ? a[63] : a[31];
		nb   = command.wide ? b[63] : b[31];
		ma   = na ? ((64'd0 - a) & mask) : a;
		mb   = nb ? ((64'd0 - b) & mask) : b;
		ca   = uns ? a : (a ^ sbit);
		cb   = uns ? b : (b ^ sbit);
		sh   = command.wide ? command.operand_b[5:0] : {1'b0, command.operand_b[4:0]};
		ax   = command.wide ? a : {{32{a[31]}}, a[31:0]};
		sum  = (a + b) & mask;
		dif  = (a - b) & mask;
		simple = 64'd0;
		fault  = cia_pkg::FAULT_NONE;
		unique case (command.operation)
			cia_pkg::OP_ADD: simple = sum;
			cia_pkg::OP_SUB: simple = dif;
			cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
				if (b == 64'd0) begin
					fault = cia_pkg::FAULT_DIVZERO;
				end else if (!uns && a == sbit && b == mask) begin
					fault = cia_pkg::FAULT_OVERFLOW;
				end
			end
			cia_pkg::OP_AND: simple = a & b;
			cia_pkg::OP_OR:  simple = a | b;
			cia_pkg::OP_XOR: simple = a ^ b;
			cia_pkg::OP_NEG: simple = 64'd0 - a;
			cia_pkg::OP_NOT: simple = ~a;
			cia_pkg::OP_SHL: simple = a << sh;
			cia_pkg::OP_SHR: simple = uns ? (a >> sh) : 64'($signed(ax) >>> sh);
			cia_pkg::OP_EQ:  simple = {63'd0, a == b};
			cia_pkg::OP_NE:  simple = {63'd0, a != b};
			cia_pkg::OP_GT:  simple = {63'd0, ca > cb};
			cia_pkg::OP_GE:  simple = {63'd0, ca >= cb};
			cia_pkg::OP_LT:  simple = {63'd0, ca < cb};
			cia_pkg::OP_LE:  simple = {63'd0, ca <= cb};
			cia_pkg::OP_CADD: begin
				simple = sum;
				if (uns ? (sum < a) : (na == nb && ((sum & sbit) != 64'd0) != na)) begin
					fault = cia_pkg::FAULT_OVERFLOW;
				end
			end
			cia_pkg::OP_CSUB: begin
				simple = dif;
				if (uns ? (a < b) : (na != nb && ((dif & sbit) != 64'd0) != na)) begin
					fault = cia_pkg::FAULT_OVERFLOW;
				end
			end
			default: simple = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.op     <= command.operation;
		side_s1.wide   <= command.wide;
		side_s1.neg_q  <= !uns && (na != nb);
		side_s1.neg_r  <= !uns && na;
		side_s1.simple <= simple;
		side_s1.fault  <= fault;
		mula_s1        <= uns ? a : ma;
		mulb_s1        <= uns ? b : mb;
		mneg_s1        <= !uns && (na != nb);
		wide_s1        <= command.wide;
		uns_s1         <= uns;
		dvd_s1         <= uns ? a : ma;
		dvs_s1         <= uns ? b : mb;
	end

	cia_mul u_mul (
		.clk  (clk),
		.a    (mula_s1),
		.b    (mulb_s1),
		.neg  (mneg_s1),
		.wide (wide_s1),
		.uns  (uns_s1),
		.prod (mul_out)
	);

	cia_div u_div (
		.clk       (clk),
		.dividend  (dvd_s1),
		.divisor   (dvs_s1),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cia_pkg::DIV_LAT; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else begin
			valid_d[0] <= valid_s1;
			for (int k = 1; k < cia_pkg::DIV_LAT; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_d[0] <= side_s1;
		for (int k = 1; k < cia_pkg::DIV_LAT; k++) begin
			side_d[k] <= side_d[k-1];
		end
		mul_d[0] <= mul_out;
		for (int k = 1; k < cia_pkg::MUL_DLY; k++) begin
			mul_d[k] <= mul_d[k-1];
		end
	end

	always_comb begin
		fin   = side_d[cia_pkg::DIV_LAT-1];
		fmask = fin.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
		res   = fin.simple;
		flt   = fin.fault;
		unique case (fin.op)
			cia_pkg::OP_MUL: res = mul_d[cia_pkg::MUL_DLY-1].lo;
			cia_pkg::OP_CMUL: begin
				res = mul_d[cia_pkg::MUL_DLY-1].lo;
				if (mul_d[cia_pkg::MUL_DLY-1].ovf) begin
					flt = cia_pkg::FAULT_OVERFLOW;
				end
			end
			cia_pkg::OP_DIV: res = fin.neg_q ? (64'd0 - quo) : quo;
			cia_pkg::OP_REM: res = fin.neg_r ? (64'd0 - rem) : rem;
			default: res = fin.simple;
		endcase
		if (flt != cia_pkg::FAULT_NONE) begin
			res = 64'd0;
		end
		res = res & fmask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_d[cia_pkg::DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q.result_value <= res;
		result_q.fault_code   <= flt;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

/* design/cia_checker.sv */
// Port-level checker for the checked integer ALU and its bind statement.
`default_nettype none
module cia_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire cia_pkg::rsp_t result
);

	assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline never holds commands off");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.fault_code != cia_pkg::FAULT_NONE |-> result.result_value == 64'd0)
		else $error("faulted result beat carries a non-zero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.fault_code == cia_pkg::FAULT_NONE ||
			result.fault_code == cia_pkg::FAULT_DIVZERO ||
			result.fault_code == cia_pkg::FAULT_OVERFLOW)
		else $error("result beat carries an undefined fault code");

	assert property (@(posedge clk) $fell(arst_n) |=> !done)
		else $error("result beat shown straight after reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(cia_pkg::DIV_LAT + 2) done)
		else $error("accepted command beat gave no result beat at the fixed latency");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the checked integer ALU with a built-in result predictor.
`default_nettype none
module tb;

	localparam int IDLE_LIMIT = 2000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	cia_pkg::cmd_t  command;
	logic           done;
	cia_pkg::rsp_t  result;

	cia_pkg::rsp_t  expected_results[$];
	int             error_count;
	int             idle_cycles;

	checked_integer_alu u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .done(done), .result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] umag(logic [63:0] x, logic neg, logic [63:0] msk);
		return neg ? ((64'd0 - x) & msk) : x;
	endfunction

	function automatic logic mul_too_big(logic [63:0] ma, logic [63:0] mb, logic [63:0] lim);
		if (ma == 64'd0 || mb == 64'd0)
			return 1'b0;
		return mb > lim / ma;
	endfunction

	function automatic cia_pkg::rsp_t alu_predict(cia_pkg::cmd_t c);
		cia_pkg::rsp_t p;
		logic [63:0]   msk, sbit, a, b, r, ca, cb, lim, q, m;
		logic          na, nb;
		logic [1:0]    flt;
		int            sh;
		msk  = c.wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
		sbit = c.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		a    = c.operand_a & msk;
		b    = c.operand_b & msk;
		na   = (a & sbit) != 64'd0;
		nb   = (b & sbit) != 64'd0;
		ca   = c.is_unsigned ? a : (a ^ sbit);
		cb   = c.is_unsigned ? b : (b ^ sbit);
		sh   = c.wide ? int'(c.operand_b[5:0]) : int'(c.operand_b[4:0]);
		r    = 64'd0;
		flt  = cia_pkg::FAULT_NONE;
		case (c.operation)
			cia_pkg::OP_ADD: r = a + b;
			cia_pkg::OP_SUB: r = a - b;
			cia_pkg::OP_MUL: r = a * b;
			cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
				if (b == 64'd0)
					flt = cia_pkg::FAULT_DIVZERO;
				else if (c.is_unsigned)
					r = (c.operation == cia_pkg::OP_DIV) ? a / b : a % b;
				else if (a == sbit && b == msk)
					flt = cia_pkg::FAULT_OVERFLOW;
				else begin
					q = umag(a, na, msk) / umag(b, nb, msk);
					m = umag(a, na, msk) % umag(b, nb, msk);
					if (c.operation == cia_pkg::OP_DIV)
						r = (na != nb) ? 64'd0 - q : q;
					else
						r = na ? 64'd0 - m : m;
				end
			end
			cia_pkg::OP_AND: r = a & b;
			cia_pkg::OP_OR:  r = a | b;
			cia_pkg::OP_XOR: r = a ^ b;
			cia_pkg::OP_NEG: r = 64'd0 - a;
			cia_pkg::OP_NOT: r = ~a;
			cia_pkg::OP_SHL: r = a << sh;
			cia_pkg::OP_SHR: r = (c.is_unsigned || !na) ? a >> sh : ~((~a & msk) >> sh);
			cia_pkg::OP_EQ:  r = {63'd0, a == b};
			cia_pkg::OP_NE:  r = {63'd0, a != b};
			cia_pkg::OP_GT:  r = {63'd0, ca > cb};
			cia_pkg::OP_GE:  r = {63'd0, ca >= cb};
			cia_pkg::OP_LT:  r = {63'd0, ca < cb};
			cia_pkg::OP_LE:  r = {63'd0, ca <= cb};
			cia_pkg::OP_CADD: begin
				r = (a + b) & msk;
				if (c.is_unsigned ? (r < a) : (na == nb && ((r & sbit) != 64'd0) != na))
					flt = cia_pkg::FAULT_OVERFLOW;
			end
			cia_pkg::OP_CSUB: begin
				r = (a - b) & msk;
				if (c.is_unsigned ? (a < b) : (na != nb && ((r & sbit) != 64'd0) != na))
					flt = cia_pkg::FAULT_OVERFLOW;
			end
			cia_pkg::OP_CMUL: begin
				r = (a * b) & msk;
				if (c.is_unsigned) begin
					if (mul_too_big(a, b, msk))
						flt = cia_pkg::FAULT_OVERFLOW;
				end else begin
					lim = (na != nb) ? sbit : sbit - 64'd1;
					if (mul_too_big(umag(a, na, msk), umag(b, nb, msk), lim))
						flt = cia_pkg::FAULT_OVERFLOW;
				end
			end
			default: r = 64'd0;
		endcase
		if (flt != cia_pkg::FAULT_NONE)
			r = 64'd0;
		p.result_value = r & msk;
		p.fault_code   = flt;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	function automatic int gap_length();
		int n;
		n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 40))
			: int'($urandom_range(0, 2));
		if ($urandom_range(0, 3) == 0)
			n = 0;
		return n;
	endfunction

	task automatic send_beat(cia_pkg::cmd_t c, bit with_gap);
		int n;
		start   <= 1'b1;
		command <= c;
		do
			@(posedge clk);
		while (busy);
		expected_results.push_back(alu_predict(c));
		if (with_gap && $urandom_range(0, 1) == 0) begin
			n = gap_length();
			if (n > 0) begin
				start <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	function automatic logic [63:0] pick_operand(logic w);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = 64'd0;
			1: v = 64'd1;
			2: v = {64{1'b1}};
			3: v = w ? 64'h8000_0000_0000_0000 : {$urandom, 32'h8000_0000};
			4: v = w ? 64'h7FFF_FFFF_FFFF_FFFF : {$urandom, 32'h7FFF_FFFF};
			5: v = {$urandom, 32'h0} | 64'($urandom_range(0, 70));
			6: v = {{32{1'b1}}, $urandom} >> $urandom_range(0, 63);
			7: v = 64'($signed({$urandom, $urandom}) >>> $urandom_range(0, 63));
			default: ;
		endcase
		return v;
	endfunction

	function automatic cia_pkg::cmd_t make_cmd(logic [4:0] op, logic w, logic u,
			logic [63:0] a, logic [63:0] b);
		cia_pkg::cmd_t c;
		c.operation = op;
		c.wide = w;
		c.is_unsigned = u;
		c.operand_a = a;
		c.operand_b = b;
		return c;
	endfunction

	task automatic test_directed();
		localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
		localparam logic [63:0] ONES = {64{1'b1}};
		send_beat(make_cmd(cia_pkg::OP_DIV, 1'b1, 1'b0, 64'd5, 64'd0), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_REM, 1'b0, 1'b1, 64'd5, 64'hFFFF_FFFF_0000_0000), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_DIV, 1'b1, 1'b0, MIN64, ONES), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_REM, 1'b0, 1'b0, 64'h8000_0000, 64'hFFFF_FFFF), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_DIV, 1'b1, 1'b1, MIN64, ONES), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_DIV, 1'b0, 1'b0, 64'hFFFF_FFF9, 64'd2), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_REM, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_SHR, 1'b1, 1'b0, MIN64, 64'hFF), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_SHR, 1'b0, 1'b1, 64'h8000_0000, 64'h3F), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_SHL, 1'b0, 1'b0, 64'd1, 64'h21), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_NEG, 1'b0, 1'b0, 64'h1, ONES), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_NOT, 1'b1, 1'b1, 64'h0, 64'h0), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_CADD, 1'b1, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_CADD, 1'b0, 1'b1, 64'hFFFF_FFFF, 64'd1), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_CSUB, 1'b1, 1'b1, 64'd0, 64'd1), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_CSUB, 1'b0, 1'b0, 64'h8000_0000, 64'd1), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_CMUL, 1'b1, 1'b0, 64'h4000_0000_0000_0000, ONES - 1),
			1'b0);
		send_beat(make_cmd(cia_pkg::OP_CMUL, 1'b1, 1'b0, 64'h4000_0000_0000_0000, 64'd2), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_CMUL, 1'b0, 1'b1, 64'h1_0000, 64'h1_0000), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_LT, 1'b1, 1'b0, MIN64, 64'd0), 1'b0);
		send_beat(make_cmd(cia_pkg::OP_LT, 1'b1, 1'b1, MIN64, 64'd0), 1'b0);
		send_beat(make_cmd(5'd31, 1'b1, 1'b1, ONES, ONES), 1'b0);
		send_beat(make_cmd(5'd21, 1'b0, 1'b0, ONES, 64'd3), 1'b1);
		for (int op = 0; op <= 20; op++)
			send_beat(make_cmd(op[4:0], 1'b1, 1'b0, ONES, MIN64), 1'b1);
	endtask

	task automatic test_random(int count);
		cia_pkg::cmd_t c;
		for (int i = 0; i < count; i++) begin
			c.operation = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(21, 31))
				: 5'($urandom_range(0, 20));
			c.wide = 1'($urandom_range(0, 1));
			c.is_unsigned = 1'($urandom_range(0, 1));
			c.operand_a = pick_operand(c.wide);
			c.operand_b = pick_operand(c.wide);
			send_beat(c, $urandom_range(0, 4) != 0);
		end
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", result.result_value, 64'd0);
			end else begin
				if (result.result_value !== expected_results[0].result_value)
					report_mismatch("result_value", result.result_value,
						expected_results[0].result_value);
				if (result.fault_code !== expected_results[0].fault_code)
					report_mismatch("fault_code", 64'(result.fault_code),
						64'(expected_results[0].fault_code));
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL checked_integer_alu");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		command = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1100);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("PASS checked_integer_alu");
		else
			$display("FAIL checked_integer_alu");
		$finish;
	end
endmodule
`default_nettype wire
